### rtl/core/utt_pkg.sv
// Shared types, constants and helpers for the UTF-16 to UTF-8 transcoder.
// Used by utt_front, utt_fifo, utt_back and utf16_to_utf8_transcoder.
// No dependencies.
package utt_pkg;

    localparam int unsigned MAX_OUTPUT_BYTES = 1024;
    localparam int unsigned CAP_W            = 11;
    localparam int unsigned CP_W             = 21;
    localparam int unsigned LEN_W            = 3;
    localparam int unsigned UNIT_W           = 16;
    localparam int unsigned QUEUE_DEPTH      = 4;
    localparam int unsigned QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(MAX_OUTPUT_BYTES);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(128);

    // byte order modes; any other code behaves as detect
    localparam logic [1:0] MODE_DETECT = 2'd0;
    localparam logic [1:0] MODE_BIG    = 2'd1;
    localparam logic [1:0] MODE_LITTLE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_BYTE_ORDER = 2'd0;
    localparam logic [1:0] REG_CAPACITY   = 2'd1;

    // pending operation slots, issued lowest first
    localparam int unsigned OP_PAIR  = 0;
    localparam int unsigned OP_UNIT  = 1;
    localparam int unsigned OP_FLUSH = 2;
    localparam int unsigned OP_TERM  = 3;
    localparam int unsigned OP_N     = 4;

    localparam logic [7:0] BOM_FE = 8'hFE;
    localparam logic [7:0] BOM_FF = 8'hFF;

    localparam logic [UNIT_W-1:0] HIGH_FIRST = 16'hD800;
    localparam logic [UNIT_W-1:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [UNIT_W-1:0] LOW_FIRST  = 16'hDC00;
    localparam logic [UNIT_W-1:0] LOW_LAST   = 16'hDFFF;
    localparam logic [CP_W-1:0]   SUPP_BASE  = 21'h10000;

    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    localparam logic [LEN_W-1:0] LEN1 = 3'd1;
    localparam logic [LEN_W-1:0] LEN2 = 3'd2;
    localparam logic [LEN_W-1:0] LEN3 = 3'd3;
    localparam logic [LEN_W-1:0] LEN4 = 3'd4;

    // one queued code point, or the terminator
    typedef struct packed {
        logic             term;
        logic [LEN_W-1:0] len;
        logic [CP_W-1:0]  cp;
    } entry_t;

    function automatic logic [LEN_W-1:0] utf8_len(input logic [CP_W-1:0] cp);
        logic [LEN_W-1:0] len;
        if (cp < 21'h80) begin
            len = LEN1;
        end else if (cp < 21'h800) begin
            len = LEN2;
        end else if (cp < 21'h10000) begin
            len = LEN3;
        end else begin
            len = LEN4;
        end
        return len;
    endfunction

endpackage

### rtl/core/utt_front.sv
// Front end: pairs text bytes into units, handles the byte order mark and
// surrogates, checks output capacity and issues code points to the queue.
// Depends on utt_pkg.
module utt_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [utt_pkg::CAP_W-1:0] cfg_data,
    output logic                  q_push,
    output utt_pkg::entry_t       q_entry,
    input  logic                  q_ready
);

    logic [1:0]                     mode_reg;
    logic [utt_pkg::CAP_W-1:0]      cap_reg;
    logic [7:0]                     held_byte_reg;
    logic                           held_valid_reg;
    logic [utt_pkg::UNIT_W-1:0]     pend_unit_reg;
    logic                           pend_valid_reg;
    logic                           first_unit_reg;
    logic                           be_reg;
    logic [utt_pkg::CAP_W-1:0]      bytes_reg;
    logic [utt_pkg::OP_N-1:0]       ops_reg;
    logic [utt_pkg::CP_W-1:0]       pair_cp_reg;
    logic [utt_pkg::UNIT_W-1:0]     unit_cp_reg;
    logic [utt_pkg::UNIT_W-1:0]     flush_cp_reg;

    logic                           accept;
    logic                           detect;
    logic                           bom_be;
    logic                           bom_le;
    logic                           skip;
    logic                           be_next;
    logic                           be;
    logic                           take;
    logic [utt_pkg::UNIT_W-1:0]     unit;
    logic                           is_high;
    logic                           is_low;
    logic                           pair_ok;
    logic [utt_pkg::CP_W-1:0]       cp_pair;
    logic                           pend_valid_next;
    logic [utt_pkg::UNIT_W-1:0]     pend_unit_next;
    logic [utt_pkg::OP_N-1:0]       ops_new;

    logic [utt_pkg::OP_N-1:0]       sel;
    logic [utt_pkg::OP_N-1:0]       ops_left;
    logic                           issue_fire;
    logic                           is_term;
    logic [utt_pkg::CP_W-1:0]       issue_cp;
    logic [utt_pkg::LEN_W-1:0]      issue_len;
    logic [utt_pkg::CAP_W-1:0]      cap_sat;
    logic [utt_pkg::CAP_W:0]        bytes_sum;
    logic                           fits;

    assign cfg_ready = 1'b1;

    // unit assembly and classification
    assign detect  = (mode_reg != utt_pkg::MODE_BIG) && (mode_reg != utt_pkg::MODE_LITTLE);
    assign bom_be  = first_unit_reg && detect &&
                     (held_byte_reg == utt_pkg::BOM_FE) && (s_tdata == utt_pkg::BOM_FF);
    assign bom_le  = first_unit_reg && detect &&
                     (held_byte_reg == utt_pkg::BOM_FF) && (s_tdata == utt_pkg::BOM_FE);
    assign skip    = held_valid_reg && (bom_be || bom_le);
    assign be_next = (first_unit_reg && detect) ? bom_be : be_reg;
    assign be      = (mode_reg == utt_pkg::MODE_BIG)    ? 1'b1 :
                     (mode_reg == utt_pkg::MODE_LITTLE) ? 1'b0 : be_next;
    assign unit    = be ? {held_byte_reg, s_tdata} : {s_tdata, held_byte_reg};
    assign take    = held_valid_reg && !skip;
    assign is_high = (unit >= utt_pkg::HIGH_FIRST) && (unit <= utt_pkg::HIGH_LAST);
    assign is_low  = (unit >= utt_pkg::LOW_FIRST) && (unit <= utt_pkg::LOW_LAST);
    assign pair_ok = pend_valid_reg && is_low;
    assign cp_pair = pair_ok ?
                     utt_pkg::SUPP_BASE +
                         utt_pkg::CP_W'({pend_unit_reg[9:0], unit[9:0]}) :
                     utt_pkg::CP_W'(pend_unit_reg);

    assign pend_valid_next = take ? (!pair_ok && is_high) : pend_valid_reg;
    assign pend_unit_next  = take ? unit : pend_unit_reg;

    always_comb begin
        ops_new                    = '0;
        ops_new[utt_pkg::OP_PAIR]  = take && pend_valid_reg;
        ops_new[utt_pkg::OP_UNIT]  = take && !pair_ok && !is_high &&
                                     (unit != '0);
        ops_new[utt_pkg::OP_FLUSH] = s_tlast && pend_valid_next;
        ops_new[utt_pkg::OP_TERM]  = s_tlast;
    end

    // issue the lowest pending operation
    assign sel        = ops_reg & (~ops_reg + utt_pkg::OP_N'(1));
    assign issue_fire = (ops_reg != '0) && q_ready;
    assign ops_left   = issue_fire ? (ops_reg & ~sel) : ops_reg;
    assign s_tready   = (ops_left == '0);
    assign accept     = s_tvalid && s_tready;

    always_comb begin
        is_term  = 1'b0;
        issue_cp = '0;
        priority if (sel[utt_pkg::OP_PAIR]) begin
            issue_cp = pair_cp_reg;
        end else if (sel[utt_pkg::OP_UNIT]) begin
            issue_cp = utt_pkg::CP_W'(unit_cp_reg);
        end else if (sel[utt_pkg::OP_FLUSH]) begin
            issue_cp = utt_pkg::CP_W'(flush_cp_reg);
        end else begin
            is_term = 1'b1;
        end
    end

    assign issue_len = utt_pkg::utf8_len(issue_cp);
    assign cap_sat   = (cap_reg > utt_pkg::CAP_MAX) ? utt_pkg::CAP_MAX : cap_reg;
    assign bytes_sum = {1'b0, bytes_reg} + (utt_pkg::CAP_W + 1)'(issue_len);
    assign fits      = bytes_sum < {1'b0, cap_sat};

    assign q_push        = issue_fire && (is_term || fits);
    assign q_entry.term  = is_term;
    assign q_entry.len   = is_term ? utt_pkg::LEN1 : issue_len;
    assign q_entry.cp    = is_term ? '0 : issue_cp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= utt_pkg::MODE_DETECT;
            cap_reg        <= utt_pkg::CAP_RESET;
            held_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            first_unit_reg <= 1'b1;
            be_reg         <= 1'b0;
            bytes_reg      <= '0;
            ops_reg        <= '0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == utt_pkg::REG_BYTE_ORDER) begin
                    mode_reg <= cfg_data[1:0];
                end else if (cfg_index == utt_pkg::REG_CAPACITY) begin
                    cap_reg <= cfg_data;
                end
            end

            if (issue_fire) begin
                if (is_term) begin
                    bytes_reg <= '0;
                end else if (fits) begin
                    bytes_reg <= bytes_sum[utt_pkg::CAP_W-1:0];
                end
            end

            ops_reg <= accept ? ops_new : ops_left;

            if (accept) begin
                if (s_tlast) begin
                    held_valid_reg <= 1'b0;
                    pend_valid_reg <= 1'b0;
                    first_unit_reg <= 1'b1;
                    be_reg         <= 1'b0;
                end else begin
                    held_valid_reg <= !held_valid_reg;
                    pend_valid_reg <= pend_valid_next;
                    if (held_valid_reg) begin
                        first_unit_reg <= 1'b0;
                        be_reg         <= be_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (!held_valid_reg) begin
                held_byte_reg <= s_tdata;
            end
            pend_unit_reg <= pend_unit_next;
            pair_cp_reg   <= cp_pair;
            unit_cp_reg   <= unit;
            flush_cp_reg  <= pend_unit_next;
        end
    end

endmodule

### rtl/core/utt_fifo.sv
// Short queue of code point entries between the front and back ends.
// Depends on utt_pkg.
module utt_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  utt_pkg::entry_t push_entry,
    output logic            push_ready,
    output logic            head_valid,
    output utt_pkg::entry_t head,
    input  logic            pop
);

    utt_pkg::entry_t                mem [utt_pkg::QUEUE_DEPTH];
    logic [utt_pkg::QPTR_W-1:0]     wptr_reg;
    logic [utt_pkg::QPTR_W-1:0]     rptr_reg;
    logic [utt_pkg::QCNT_W-1:0]     count_reg;
    logic                           do_push;
    logic                           do_pop;

    assign push_ready = (count_reg != utt_pkg::QCNT_W'(utt_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= wptr_reg + utt_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + utt_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + utt_pkg::QCNT_W'(1);
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - utt_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wptr_reg] <= push_entry;
        end
    end

endmodule

### rtl/core/utt_back.sv
// Back end: expands queued code points into UTF-8 bytes, one output word
// per cycle unless stalled, via a registered output stage. Uses utt_pkg.
module utt_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            head_valid,
    input  utt_pkg::entry_t head,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);

    logic [1:0]                 idx_reg;
    logic                       m_tvalid_reg;
    logic [7:0]                 m_tdata_reg;
    logic                       m_tlast_reg;
    logic                       load;
    logic                       at_end;
    logic [1:0]                 remain;
    logic [7:0]                 lead_byte;
    logic [7:0]                 cont_byte;
    logic [7:0]                 byte_next;

    assign load   = head_valid && (!m_tvalid_reg || m_tready);
    assign remain = 2'(head.len - utt_pkg::LEN1) - idx_reg;
    assign at_end = (remain == 2'd0);
    assign pop    = load && at_end;

    always_comb begin
        unique case (head.len)
            utt_pkg::LEN2: lead_byte = utt_pkg::LEAD2 | {3'b000, head.cp[10:6]};
            utt_pkg::LEN3: lead_byte = utt_pkg::LEAD3 | {4'b0000, head.cp[15:12]};
            utt_pkg::LEN4: lead_byte = utt_pkg::LEAD4 | {5'b00000, head.cp[20:18]};
            default:       lead_byte = head.cp[7:0];
        endcase
    end

    // continuation bytes carry six bits each, most significant first
    always_comb begin
        unique case (remain)
            2'd0:    cont_byte = utt_pkg::CONT | {2'b00, head.cp[5:0]};
            2'd1:    cont_byte = utt_pkg::CONT | {2'b00, head.cp[11:6]};
            default: cont_byte = utt_pkg::CONT | {2'b00, head.cp[17:12]};
        endcase
    end

    assign byte_next = (idx_reg == 2'd0) ? lead_byte : cont_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_tvalid_reg <= 1'b1;
                idx_reg      <= at_end ? 2'd0 : idx_reg + 2'd1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= head.term ? 8'h00 : byte_next;
            m_tlast_reg <= head.term;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### rtl/core/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder, top level.
// Instantiates utt_front, utt_fifo and utt_back; uses utt_pkg.

// Takes UTF-16 text one raw byte per input word (tlast on the final byte)
// and sends out UTF-8, one byte per output word, closed by a NUL word with
// tlast set. The front end takes one text byte per cycle while the queue has
// room; a byte that issues more than one code point or terminator (a lone
// surrogate followed by another unit, or a final byte that also ends a unit
// or flushes a surrogate) holds s_tready low until each extra issue is made,
// dropped code points included. The back end sends one byte per cycle while
// m_tready is high, so a code point takes as many output words as its UTF-8
// length. A four-entry queue parts the two ends. Register 0 sets the byte
// order (0 detect a mark, little endian without one; 1 big; 2 little),
// register 1 the output capacity in bytes including the NUL; write them
// only while the block is idle.
module utf16_to_utf8_transcoder (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // text_byte
    input  logic                      s_tlast,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,   // out_byte
    output logic                      m_tlast,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [utt_pkg::CAP_W-1:0] cfg_data
);

    logic            q_push;
    logic            q_ready;
    utt_pkg::entry_t q_entry;
    logic            head_valid;
    utt_pkg::entry_t head;
    logic            pop;

    utt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_push    (q_push),
        .q_entry   (q_entry),
        .q_ready   (q_ready)
    );

    utt_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .push_ready (q_ready),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    utt_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
